[rtl/ffha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
    localparam int unsigned HEAP_BYTES_DEF   = 2097152;
    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam int unsigned HEADER_BYTES_DEF = 20;
    localparam int unsigned ALIGN_MASK       = 7;
    localparam int unsigned SIZE_W           = 21;
    localparam int unsigned REQ_W            = 22;
    localparam int unsigned ADDR_W           = 32;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // table entry: offset, size, free mark
    typedef struct packed {
        logic [SIZE_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;
endpackage
`default_nettype wire

[rtl/ffha_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [21:0] request_bytes;
    logic [31:0] free_address;
    modport source (output valid, req_type, request_bytes, free_address, input ready);
    modport sink   (input valid, req_type, request_bytes, free_address, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] data_address;
    logic [20:0] granted_bytes;
    modport source (output valid, status, data_address, granted_bytes, input ready);
    modport sink   (input valid, status, data_address, granted_bytes, output ready);
endinterface
`default_nettype wire

[rtl/ffha_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Block table memory: one write port, one registered read port.
module ffha_table
    import ffha_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);
    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end
    assign o_rdata = r_rd;
endmodule
`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow: a zero-size request goes straight to the response; other requests walk the table
//   entry by entry, and a split (insert) or a merge (remove) then shifts the entries
//   after the found one, one entry a step.
// Throughput: one request at a time; next accepted once the response beat is taken.
// Reset (sync, active low): clears heap_base, then a setup pass writes entry 0
//   (whole heap free) before the first request is accepted.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ffha_req_if.sink         i_req,
    ffha_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [SIZE_W-1:0] HDR   = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] INITSZ = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CNT_W-1:0]  MAXC  = CNT_W'(MAX_BLOCKS);
    localparam logic [1:0] REG_HEAP_BASE = 2'd0;

    // sequencer: walk reads entries; insert/remove shift the table one entry a step
    typedef enum logic [11:0] {
        S_INIT  = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_RD    = 12'b000000000100, // address issued, data next cycle
        S_CHK   = 12'b000000001000, // compare entry
        S_INSRD = 12'b000000010000, // insert: read k-1
        S_INSWR = 12'b000000100000, // insert: write k
        S_FNX   = 12'b000001000000, // free: read next neighbor
        S_FPV   = 12'b000010000000, // free: read previous neighbor
        S_RMRD  = 12'b000100000000, // remove: read k+1
        S_RMWR  = 12'b001000000000, // remove: write k
        S_FIN   = 12'b010000000000, // final write / merge step
        S_RSP   = 12'b100000000000
    } t_state;

    t_state r_st, n_st;
    logic [31:0]       r_base;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_i, n_i;        // entry under walk / found index
    logic [CNT_W-1:0]  r_k, n_k;        // shift pointer
    logic              r_type;
    logic [SIZE_W+1:0] r_size;          // rounded request, wide enough for oversize asks
    logic [31:0]       r_faddr;
    t_entry            r_cur, n_cur;    // found entry, updated
    t_entry            r_new, n_new;    // entry to insert
    logic              r_mrg2, n_mrg2;  // free: previous-neighbor check pending after a next merge
    logic              r_ins, n_ins;
    logic [1:0]        r_stat, n_stat;
    logic [31:0]       r_daddr, n_daddr;
    logic [SIZE_W-1:0] r_gr, n_gr;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    t_entry            wdata, rd;

    ffha_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == REG_HEAP_BASE) ? r_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (psel && penable && pwrite && paddr == REG_HEAP_BASE) begin
            r_base <= pwdata;
        end
    end

    assign i_req.ready = (r_st == S_IDLE);
    assign o_rsp.valid = (r_st == S_RSP);
    assign o_rsp.status = r_stat;
    assign o_rsp.data_address = r_daddr;
    assign o_rsp.granted_bytes = r_gr;

    // shared compare/add unit inputs
    logic [31:0] ent_addr;
    assign ent_addr = r_base + 32'(rd.offset) + 32'(HDR);

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_k = r_k; n_cur = r_cur; n_new = r_new;
        n_mrg2 = r_mrg2; n_ins = r_ins; n_stat = r_stat; n_daddr = r_daddr; n_gr = r_gr;
        we = 1'b0; waddr = r_i[IDX_W-1:0]; wdata = r_cur; raddr = r_i[IDX_W-1:0];
        unique case (r_st)
            S_INIT: begin
                we = 1'b1; waddr = '0;
                wdata = '{offset: '0, size: INITSZ, free: 1'b1};
                n_cnt = CNT_W'(1);
                n_st = S_IDLE;
            end
            S_IDLE: begin
                n_i = '0; raddr = '0;
                if (i_req.valid) begin
                    n_stat = (i_req.req_type == REQ_FREE) ? ST_BAD_FREE : ST_NO_FIT;
                    n_daddr = '0; n_gr = '0;
                    if (i_req.req_type == REQ_ALLOC && i_req.request_bytes == '0) begin
                        n_stat = ST_ZERO; n_st = S_RSP;
                    end else begin
                        n_st = S_RD;
                    end
                end
            end
            S_RD: begin
                n_st = S_CHK;
            end
            S_CHK: begin
                // rd holds entry r_i
                if (r_type == REQ_ALLOC) begin
                    if (rd.free && {2'b00, rd.size} >= r_size) begin
                        n_cur = rd; n_cur.free = 1'b0;
                        n_stat = ST_OK;
                        n_daddr = ent_addr;
                        n_ins = 1'b0;
                        if ({2'b00, rd.size} >= r_size + (SIZE_W+2)'(HDR + 8)
                            && r_cnt < MAXC) begin
                            n_cur.size = r_size[SIZE_W-1:0];
                            n_new = '{offset: rd.offset + HDR + r_size[SIZE_W-1:0],
                                      size: rd.size - r_size[SIZE_W-1:0] - HDR,
                                      free: 1'b1};
                            n_ins = 1'b1;
                        end
                        n_gr = n_cur.size;
                        n_k = r_cnt;
                        n_st = n_ins ? S_INSRD : S_FIN;
                    end else if (r_i + 1'b1 < r_cnt) begin
                        n_i = r_i + 1'b1; raddr = n_i[IDX_W-1:0]; n_st = S_RD;
                    end else begin
                        n_st = S_RSP;
                    end
                end else begin
                    if (!rd.free && ent_addr == r_faddr) begin
                        n_cur = rd; n_cur.free = 1'b1;
                        n_stat = ST_OK; n_gr = rd.size;
                        if (r_i + 1'b1 < r_cnt) begin
                            n_k = r_i + 1'b1; raddr = n_k[IDX_W-1:0]; n_st = S_FNX;
                        end else begin
                            n_st = S_FPV; raddr = r_i[IDX_W-1:0] - 1'b1;
                        end
                    end else if (r_i + 1'b1 < r_cnt) begin
                        n_i = r_i + 1'b1; raddr = n_i[IDX_W-1:0]; n_st = S_RD;
                    end else begin
                        n_st = S_RSP;
                    end
                end
            end
            S_INSRD: begin
                // shift entries [i+1 .. cnt-1] up by one
                if (r_k > r_i + 1'b1) begin
                    raddr = r_k[IDX_W-1:0] - 1'b1; n_st = S_INSWR;
                end else begin
                    we = 1'b1; waddr = r_k[IDX_W-1:0]; wdata = r_new;
                    n_cnt = r_cnt + 1'b1;
                    n_st = S_FIN;
                end
            end
            S_INSWR: begin
                we = 1'b1; waddr = r_k[IDX_W-1:0]; wdata = rd;
                n_k = r_k - 1'b1; n_st = S_INSRD;
            end
            S_FNX: begin
                if (rd.free) begin
                    n_cur.size = r_cur.size + HDR + rd.size;
                    n_k = r_i + 1'b1; n_mrg2 = 1'b1;
                    raddr = n_k[IDX_W-1:0] + 1'b1;
                    n_st = S_RMRD;
                end else begin
                    raddr = r_i[IDX_W-1:0] - 1'b1;
                    n_st = S_FPV;
                end
            end
            S_FPV: begin
                // previous neighbor (skip when i == 0)
                n_mrg2 = 1'b0;
                if (r_i != '0 && rd.free) begin
                    n_cur.offset = rd.offset; n_cur.free = 1'b1;
                    n_cur.size = rd.size + HDR + r_cur.size;
                    we = 1'b1; waddr = r_i[IDX_W-1:0] - 1'b1; wdata = n_cur;
                    n_k = r_i; n_i = r_i - 1'b1;
                    raddr = r_i[IDX_W-1:0] + 1'b1;
                    n_st = S_RMRD;
                end else begin
                    n_st = S_FIN;
                end
            end
            S_RMRD: begin
                // move entry k+1 down to k until the end
                if (r_k + 1'b1 < r_cnt) begin
                    raddr = r_k[IDX_W-1:0] + 1'b1; n_st = S_RMWR;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_mrg2) begin
                        n_mrg2 = 1'b0;
                        raddr = r_i[IDX_W-1:0] - 1'b1;
                        n_st = S_FPV;
                    end else begin
                        n_st = S_RSP;
                    end
                end
            end
            S_RMWR: begin
                we = 1'b1; waddr = r_k[IDX_W-1:0]; wdata = rd;
                n_k = r_k + 1'b1; n_st = S_RMRD;
            end
            S_FIN: begin
                we = 1'b1; waddr = r_i[IDX_W-1:0]; wdata = r_cur;
                n_st = S_RSP;
            end
            S_RSP: begin
                if (o_rsp.ready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_cnt <= '0;
            r_mrg2 <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_mrg2 <= n_mrg2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_k <= n_k; r_cur <= n_cur; r_new <= n_new; r_ins <= n_ins;
        r_stat <= n_stat; r_daddr <= n_daddr; r_gr <= n_gr;
        if (r_st == S_IDLE) begin
            r_type <= i_req.req_type;
            r_size <= ((SIZE_W+2)'(i_req.request_bytes) + (SIZE_W+2)'(ALIGN_MASK))
                      & ~(SIZE_W+2)'(ALIGN_MASK);
            r_faddr <= i_req.free_address;
        end
    end
endmodule
`default_nettype wire

[rtl/ffha_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffha_checker
    import ffha_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_status,
    input wire logic [31:0] rsp_addr,
    input wire logic [20:0] rsp_gr
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req_ready && rsp_valid)) else $error("ready during response");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_addr == 32'd0 && rsp_gr == 21'd0)
        else $error("error beat carries data");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("response dropped");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready) else $error("second accept");
endmodule

bind first_fit_heap_allocator ffha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_status(o_rsp.status), .rsp_addr(o_rsp.data_address),
    .rsp_gr(o_rsp.granted_bytes)
);
`default_nettype wire
